FILE: src/gfms_pkg.sv
// ----------------------------------------------------------------------------
// gfms_pkg: shared types and codes for the gap filler
// Sequencer states, result kind codes and the control groups that pass
// between the sequencer, the sum unit and the top level.
// ----------------------------------------------------------------------------
package gfms_pkg;

    localparam int unsigned KIND_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SUM    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERROR  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_EMIT,
        S_ERR,
        S_SUM
    } t_state;

    // Strobes from the sequencer to the running sum unit.
    typedef struct packed {
        logic update;
        logic clear;
    } t_acc_ctl;

    // Result request from the sequencer to the output register.
    typedef struct packed {
        logic                 load;
        logic [KIND_BITS-1:0] kind;
        logic                 last;
    } t_emit;

endpackage

FILE: src/gfms_acc.sv
// ----------------------------------------------------------------------------
// gfms_acc: saturating maximum subarray sum unit
// One shared saturating add and compare, used once per emitted sample to
// advance the running sum and the best sum.
// ----------------------------------------------------------------------------
module gfms_acc
    import gfms_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_acc_ctl                   i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_val,
    output logic signed [SUM_BITS-1:0] o_best
);

    localparam int EXT_BITS = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

    logic signed [SUM_BITS-1:0] r_run;
    logic signed [SUM_BITS-1:0] n_run;
    logic signed [SUM_BITS-1:0] r_best;
    logic signed [SUM_BITS-1:0] n_best;
    logic                       r_have_any;

    logic signed [EXT_BITS-1:0] w_ext;
    logic signed [SUM_BITS-1:0] w_clamp;
    logic        [SUM_BITS:0]   w_add;
    logic                       w_fits;
    logic                       w_run_pos;

    always_comb begin
        w_ext  = EXT_BITS'(i_val);
        // The sample fits when all bits above the sum's sign agree with it.
        w_fits = (&w_ext[EXT_BITS-1:SUM_BITS-1]) || !(|w_ext[EXT_BITS-1:SUM_BITS-1]);
        if (w_fits) begin
            w_clamp = w_ext[SUM_BITS-1:0];
        end else if (w_ext[EXT_BITS-1]) begin
            w_clamp = SUM_MIN;
        end else begin
            w_clamp = SUM_MAX;
        end

        w_run_pos = !r_run[SUM_BITS-1] && (|r_run);
        w_add     = {r_run[SUM_BITS-1], r_run} + {w_clamp[SUM_BITS-1], w_clamp};

        if (r_have_any && w_run_pos) begin
            if (w_add[SUM_BITS] != w_add[SUM_BITS-1]) begin
                n_run = w_add[SUM_BITS] ? SUM_MIN : SUM_MAX;
            end else begin
                n_run = w_add[SUM_BITS-1:0];
            end
        end else begin
            n_run = w_clamp;
        end

        if (!r_have_any || (n_run >= r_best)) begin
            n_best = n_run;
        end else begin
            n_best = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_run      <= '0;
            r_best     <= SUM_MIN;
            r_have_any <= 1'b0;
        end else if (i_ctl.update) begin
            r_run      <= n_run;
            r_best     <= n_best;
            r_have_any <= 1'b1;
        end
    end

    assign o_best = r_best;

endmodule

FILE: src/gfms_seq.sv
// ----------------------------------------------------------------------------
// gfms_seq: gap fill sequencer
// Holds the pending gap count and the last emitted sample, and steps through
// the fills of a closed gap one sample at a time.
// ----------------------------------------------------------------------------
module gfms_seq
    import gfms_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_GAP     = 62
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_missing,
    input  logic                          i_last_in,
    input  logic                          i_out_free,
    output t_emit                         o_emit,
    output t_acc_ctl                      o_acc,
    output logic signed [SAMPLE_BITS-1:0] o_val
);

    localparam int CNT_W = $clog2(MAX_GAP + 2);

    t_state r_state;
    t_state n_state;

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic                          r_have_prev;
    logic [CNT_W-1:0]              r_pending;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_final;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_missing;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_val;

    logic                          w_accept;
    logic                          w_hold;
    logic                          w_gap_full;
    logic                          w_more;
    logic        [SAMPLE_BITS:0]   w_pair;
    logic signed [SAMPLE_BITS-1:0] w_fill;

    assign w_accept   = i_valid && o_ready;
    assign w_hold     = i_missing && !i_last_in;
    assign w_gap_full = (r_pending == CNT_W'(MAX_GAP));
    assign w_more     = (r_cnt != '0) || r_final;

    // Arithmetic shift of the widened sum gives the floor of the mean.
    always_comb begin
        w_pair = {r_prev[SAMPLE_BITS-1], r_prev} + {r_sample[SAMPLE_BITS-1], r_sample};
        if (r_cnt == '0) begin
            w_fill = r_sample;
        end else if (r_missing) begin
            w_fill = r_have_prev ? r_prev : '0;
        end else begin
            w_fill = r_have_prev ? signed'(w_pair[SAMPLE_BITS:1]) : r_sample;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_hold) begin
                        n_state = w_gap_full ? S_ERR : S_IDLE;
                    end else begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) begin
                    if (w_more) begin
                        n_state = S_CALC;
                    end else begin
                        n_state = r_last ? S_SUM : S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready       = 1'b0;
        o_emit.load   = 1'b0;
        o_emit.kind   = KIND_SAMPLE;
        o_emit.last   = 1'b0;
        o_acc.update  = 1'b0;
        o_acc.clear   = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_CALC: ;
            S_EMIT: begin
                o_emit.load  = i_out_free;
                o_emit.kind  = KIND_SAMPLE;
                o_emit.last  = !w_more && !r_last;
                o_acc.update = i_out_free;
            end
            S_ERR: begin
                o_emit.load = i_out_free;
                o_emit.kind = KIND_ERROR;
                o_emit.last = 1'b1;
            end
            S_SUM: begin
                o_emit.load = i_out_free;
                o_emit.kind = KIND_SUM;
                o_emit.last = 1'b1;
                o_acc.clear = i_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_pending   <= '0;
            r_cnt       <= '0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_hold) begin
                            r_pending <= w_gap_full ? '0 : r_pending + 1'b1;
                        end else begin
                            r_cnt     <= i_missing ? r_pending + 1'b1 : r_pending;
                            r_final   <= !i_missing;
                            r_pending <= '0;
                        end
                    end
                end
                S_CALC: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_final <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_prev      <= r_val;
                        r_have_prev <= 1'b1;
                    end
                end
                S_ERR: ;
                S_SUM: begin
                    if (i_out_free) begin
                        r_prev      <= '0;
                        r_have_prev <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample  <= i_sample;
            r_missing <= i_missing;
            r_last    <= i_last_in;
        end
        if (r_state == S_CALC) begin
            r_val <= w_fill;
        end
    end

    assign o_val = r_val;

endmodule

FILE: src/gap_fill_and_max_subarray.sv
// ----------------------------------------------------------------------------
// gap_fill_and_max_subarray: missing sample filler with maximum subarray sum
// Top level: sequencer, sum unit and the result register.
// ----------------------------------------------------------------------------
// Usage.
// The input channel (i_valid / o_ready) takes one sample beat with a missing
// flag and a last mark. A missing beat that is not last is counted and gives
// no result; o_ready is back high in the next cycle. A present sample closes
// the gap: each pending sample is filled with the floor of the mean of the
// previous output and the new sample, then the sample itself follows. A
// missing last beat fills the open gap with the previous output. After a
// last beat, one more result carries the saturated maximum subarray sum, and
// the block returns to its reset state for the next sequence. A gap longer
// than MAX_GAP gives one error result and drops the gap; that beat holds
// o_ready low until the error result is loaded.
// Each emitted sample is first filled (S_CALC), then loaded and accumulated
// (S_EMIT), so an item holds o_ready low until all of its results are
// loaded, plus the sum result after a last beat; results are held in the
// result register that drives the output channel (o_valid / i_ready).
// A stalled receiver holds the result register and the sequencer waits.
// Reset is synchronous and clears all sequence state.
// ----------------------------------------------------------------------------
module gap_fill_and_max_subarray
    import gfms_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_GAP     = 62,
    parameter int SUM_BITS    = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_missing,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [KIND_BITS-1:0]          o_kind,
    output logic signed [SUM_BITS-1:0]    o_value,
    output logic                          o_last_out
);

    localparam int EXT_BITS = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    t_emit                         w_emit;
    t_acc_ctl                      w_acc;
    logic signed [SAMPLE_BITS-1:0] w_val;
    logic signed [SUM_BITS-1:0]    w_best;
    logic signed [EXT_BITS-1:0]    w_val_ext;
    logic                          w_out_free;

    logic                          r_valid;
    logic [KIND_BITS-1:0]          r_kind;
    logic signed [SUM_BITS-1:0]    r_value;
    logic                          r_last;
    logic signed [SUM_BITS-1:0]    n_value;

    assign w_out_free = !r_valid || i_ready;

    gfms_seq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_GAP     (MAX_GAP)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_missing  (i_missing),
        .i_last_in  (i_last_in),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_acc      (w_acc),
        .o_val      (w_val)
    );

    gfms_acc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_acc),
        .i_val   (w_val),
        .o_best  (w_best)
    );

    // A sample wider than the sum is reported by its low bits.
    always_comb begin
        w_val_ext = EXT_BITS'(w_val);
        unique case (w_emit.kind)
            KIND_SAMPLE: n_value = w_val_ext[SUM_BITS-1:0];
            KIND_SUM:    n_value = w_best;
            default:     n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_kind  <= w_emit.kind;
            r_value <= n_value;
            r_last  <= w_emit.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_value    = r_value;
    assign o_last_out = r_last;

endmodule

FILE: src/gfms_checker.sv
// ----------------------------------------------------------------------------
// gfms_checker: port level checks for the gap filler
// Watches the top level's channels and flags results that break the
// block's rules on kinds, last marks and busy time.
// ----------------------------------------------------------------------------
module gfms_checker
    import gfms_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          i_missing,
    input logic                          i_last_in,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [KIND_BITS-1:0]          o_kind,
    input logic signed [SUM_BITS-1:0]    o_value,
    input logic                          o_last_out
);

    // A waiting input beat holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_sample) && $stable(i_missing)
            && $stable(i_last_in))
        else $error("input beat changed while waiting");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_value)
            && $stable(o_last_out))
        else $error("result beat changed while stalled");

    // The sum closes the sequence, so it always carries the last mark.
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_SUM) |-> o_last_out)
        else $error("sum result without last mark");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_ERROR) |-> o_last_out && (o_value == '0))
        else $error("error result malformed");

    // Any beat that produces samples keeps the input closed in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (!i_missing || i_last_in) |=> !o_ready)
        else $error("input reopened while results are being formed");

endmodule

bind gap_fill_and_max_subarray gfms_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
) u_gfms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_sample   (i_sample),
    .i_missing  (i_missing),
    .i_last_in  (i_last_in),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_kind     (o_kind),
    .o_value    (o_value),
    .o_last_out (o_last_out)
);
